>>> rtl/tcsp_pkg.sv
// tcsp_pkg: shared types, telnet protocol codes and reply byte generation
// for the telnet client stream parser.
// Depends on nothing; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package tcsp_pkg;

	// Telnet command codes
	localparam logic [7:0] T_IAC  = 8'd255;
	localparam logic [7:0] T_DONT = 8'd254;
	localparam logic [7:0] T_DO   = 8'd253;
	localparam logic [7:0] T_WONT = 8'd252;
	localparam logic [7:0] T_WILL = 8'd251;
	localparam logic [7:0] T_SB   = 8'd250;
	localparam logic [7:0] T_SE   = 8'd240;

	// Option codes
	localparam logic [7:0] OPT_WINSIZE     = 8'd31;
	localparam logic [7:0] OPT_TTYPE       = 8'd24;
	localparam logic [7:0] OPT_SGA         = 8'd3;
	localparam logic [7:0] OPT_REMOTE_ECHO = 8'd1;

	// Terminal-type subcommands
	localparam logic [7:0] TTYPE_SEND = 8'd1;
	localparam logic [7:0] TTYPE_IS   = 8'd0;

	// Terminal name sent in the TERMINAL-TYPE IS reply
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_I = 8'h49;

	// Window size register reset values
	localparam logic [15:0] COLS_RESET = 16'd116;
	localparam logic [15:0] ROWS_RESET = 16'd41;

	// Configuration register byte addresses
	localparam logic [2:0] ADDR_COLS = 3'h0;
	localparam logic [2:0] ADDR_ROWS = 3'h4;

	// Byte position within one command's output run (up to 12 bytes)
	typedef logic [3:0] idx_t;

	// Command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,  // one byte to the terminal
		CMD_REPLY = 2'd1,  // IAC verb option
		CMD_NAWS  = 2'd2,  // IAC WILL NAWS plus window size subnegotiation
		CMD_TTYPE = 2'd3   // IAC SB TTYPE IS "ANSI" IAC SE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  b0;   // data byte, or reply verb
		logic [7:0]  b1;   // reply option
	} cmd_t;

	// Number of bytes a command expands to
	function automatic idx_t cmd_len(input cmd_kind_t kind);
		idx_t len;
		case (kind)
			CMD_DATA:  len = 4'd1;
			CMD_REPLY: len = 4'd3;
			CMD_NAWS:  len = 4'd12;
			CMD_TTYPE: len = 4'd10;
			default:   len = 4'd1;
		endcase
		return len;
	endfunction

	// Byte at position idx of a command's run
	function automatic logic [7:0] cmd_byte(input cmd_t cmd, input idx_t idx,
			input logic [15:0] cols, input logic [15:0] rows);
		logic [7:0] b;
		b = T_IAC;
		case (cmd.kind)
			CMD_DATA: b = cmd.b0;
			CMD_REPLY: begin
				case (idx)
					4'd0:    b = T_IAC;
					4'd1:    b = cmd.b0;
					default: b = cmd.b1;
				endcase
			end
			CMD_NAWS: begin
				case (idx)
					4'd0:    b = T_IAC;
					4'd1:    b = T_WILL;
					4'd2:    b = OPT_WINSIZE;
					4'd3:    b = T_IAC;
					4'd4:    b = T_SB;
					4'd5:    b = OPT_WINSIZE;
					4'd6:    b = cols[15:8];
					4'd7:    b = cols[7:0];
					4'd8:    b = rows[15:8];
					4'd9:    b = rows[7:0];
					4'd10:   b = T_IAC;
					default: b = T_SE;
				endcase
			end
			CMD_TTYPE: begin
				case (idx)
					4'd0:    b = T_IAC;
					4'd1:    b = T_SB;
					4'd2:    b = OPT_TTYPE;
					4'd3:    b = TTYPE_IS;
					4'd4:    b = CH_A;
					4'd5:    b = CH_N;
					4'd6:    b = CH_S;
					4'd7:    b = CH_I;
					4'd8:    b = T_IAC;
					default: b = T_SE;
				endcase
			end
			default: b = cmd.b0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/tcsp_front.sv
// tcsp_front: telnet receive state machine. Classifies each received byte
// and pushes at most one command per byte into the command queue.
// Depends on tcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     rx_byte,
	output tcsp_pkg::cmd_t      cmd,
	output logic                push
);

	typedef enum logic [5:0] {
		PH_DATA   = 6'b000001,
		PH_IAC    = 6'b000010,
		PH_SUBOPT = 6'b000100,
		PH_OPT    = 6'b001000,
		PH_SUB    = 6'b010000,
		PH_SUBIAC = 6'b100000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] verb_q, verb_d;
	logic [7:0] sub_opt_q, sub_opt_d;
	logic [7:0] sub_first_q, sub_first_d;
	logic       sub_has_q, sub_has_d;

	// Reply command for a verb and its option
	function automatic tcsp_pkg::cmd_t answer(input logic [7:0] verb,
			input logic [7:0] opt);
		tcsp_pkg::cmd_t c;
		c.kind = tcsp_pkg::CMD_REPLY;
		c.b1   = opt;
		c.b0   = tcsp_pkg::T_DONT;
		case (verb)
			tcsp_pkg::T_DO: begin
				if (opt == tcsp_pkg::OPT_WINSIZE) begin
					c.kind = tcsp_pkg::CMD_NAWS;
					c.b0   = tcsp_pkg::T_WILL;
				end else if (opt == tcsp_pkg::OPT_TTYPE) begin
					c.b0 = tcsp_pkg::T_WILL;
				end else begin
					c.b0 = tcsp_pkg::T_WONT;
				end
			end
			tcsp_pkg::T_DONT: c.b0 = tcsp_pkg::T_WONT;
			tcsp_pkg::T_WILL: begin
				if (opt == tcsp_pkg::OPT_SGA || opt == tcsp_pkg::OPT_REMOTE_ECHO)
					c.b0 = tcsp_pkg::T_DO;
				else
					c.b0 = tcsp_pkg::T_DONT;
			end
			default: c.b0 = tcsp_pkg::T_DONT;
		endcase
		return c;
	endfunction

	// Next state and command for the accepted byte
	always_comb begin
		phase_d     = phase_q;
		verb_d      = verb_q;
		sub_opt_d   = sub_opt_q;
		sub_first_d = sub_first_q;
		sub_has_d   = sub_has_q;
		push        = 1'b0;
		cmd.kind    = tcsp_pkg::CMD_DATA;
		cmd.b0      = rx_byte;
		cmd.b1      = rx_byte;
		if (accept) begin
			case (phase_q)
				PH_IAC: begin
					if (rx_byte == tcsp_pkg::T_IAC) begin
						push    = 1'b1;
						phase_d = PH_DATA;
					end else if (rx_byte == tcsp_pkg::T_DO || rx_byte == tcsp_pkg::T_DONT ||
							rx_byte == tcsp_pkg::T_WILL || rx_byte == tcsp_pkg::T_WONT) begin
						verb_d  = rx_byte;
						phase_d = PH_OPT;
					end else if (rx_byte == tcsp_pkg::T_SB) begin
						sub_has_d = 1'b0;
						phase_d   = PH_SUBOPT;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_SUBOPT: begin
					sub_opt_d = rx_byte;
					sub_has_d = 1'b0;
					phase_d   = PH_SUB;
				end
				PH_OPT: begin
					push    = 1'b1;
					cmd     = answer(verb_q, rx_byte);
					phase_d = PH_DATA;
				end
				PH_SUB: begin
					if (rx_byte == tcsp_pkg::T_IAC) begin
						phase_d = PH_SUBIAC;
					end else if (!sub_has_q) begin
						sub_first_d = rx_byte;
						sub_has_d   = 1'b1;
					end
				end
				PH_SUBIAC: begin
					if (rx_byte == tcsp_pkg::T_SE) begin
						if (sub_opt_q == tcsp_pkg::OPT_TTYPE && sub_has_q &&
								sub_first_q == tcsp_pkg::TTYPE_SEND) begin
							push     = 1'b1;
							cmd.kind = tcsp_pkg::CMD_TTYPE;
						end
						phase_d = PH_DATA;
					end else if (rx_byte == tcsp_pkg::T_IAC) begin
						// doubled IAC counts as a data byte
						if (!sub_has_q) begin
							sub_first_d = tcsp_pkg::T_IAC;
							sub_has_d   = 1'b1;
						end
						phase_d = PH_SUB;
					end else begin
						phase_d = PH_DATA;
					end
				end
				default: begin
					if (rx_byte == tcsp_pkg::T_IAC)
						phase_d = PH_IAC;
					else
						push = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			verb_q      <= '0;
			sub_opt_q   <= '0;
			sub_first_q <= '0;
			sub_has_q   <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			verb_q      <= verb_d;
			sub_opt_q   <= sub_opt_d;
			sub_first_q <= sub_first_d;
			sub_has_q   <= sub_has_d;
		end
	end

	// Verb is always a negotiation verb while waiting for its option
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OPT |-> (verb_q == tcsp_pkg::T_DO || verb_q == tcsp_pkg::T_DONT ||
			verb_q == tcsp_pkg::T_WILL || verb_q == tcsp_pkg::T_WONT))
		else $error("front: bad pending verb");

	// A command is pushed only for an accepted byte
	assert property (@(posedge clk) disable iff (!arst_n) push |-> accept)
		else $error("front: push without transfer");

endmodule

`default_nettype wire

>>> rtl/tcsp_queue.sv
// tcsp_queue: short command queue between the parser front and the byte
// generating back end.
// Depends on tcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  tcsp_pkg::cmd_t      push_cmd,
	input  wire logic           pop,
	output tcsp_pkg::cmd_t      head,
	output logic                head_valid,
	output logic                full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tcsp_pkg::cmd_t entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("queue: push while full");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue: pop while empty");

endmodule

`default_nettype wire

>>> rtl/tcsp_back.sv
// tcsp_back: expands queued commands into output bytes, one per cycle while
// out_stall is low, through a registered output stage.
// Depends on tcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcsp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  tcsp_pkg::cmd_t      head,
	input  wire logic           head_valid,
	output logic                pop,
	input  wire logic [15:0]    cols,
	input  wire logic [15:0]    rows,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                to_network,
	output logic                run_last
);

	tcsp_pkg::idx_t idx_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_net_q;
	logic           out_last_q;
	logic           load;
	logic           fire;
	logic           last;

	// Output register is free when empty or being taken
	assign load = !out_valid_q || !out_stall;
	assign fire = load && head_valid;
	assign last = (idx_q == tcsp_pkg::cmd_len(head.kind) - 4'd1);
	assign pop  = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (fire)
				idx_q <= last ? '0 : idx_q + 4'd1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= tcsp_pkg::cmd_byte(head, idx_q, cols, rows);
			out_net_q  <= (head.kind != tcsp_pkg::CMD_DATA);
			out_last_q <= last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign to_network = out_net_q;
	assign run_last   = out_last_q;

	// Terminal bytes always close their run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_net_q |-> out_last_q)
		else $error("back: terminal byte not last");

	// Mid-run position needs a command at the queue head
	assert property (@(posedge clk) disable iff (!arst_n) idx_q != '0 |-> head_valid)
		else $error("back: run position without command");

endmodule

`default_nettype wire

>>> rtl/telnet_client_stream_parser.sv
// Telnet client stream parser, top level: configuration registers, parser
// front, command queue and byte generator.
// Depends on tcsp_pkg, tcsp_front, tcsp_queue, tcsp_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one server byte per cycle while the command queue has room, and gives
// one output byte per cycle while out_stall is low. A byte is accepted in the
// cycle it arrives while the command queue has room, and its first output byte
// goes through the queue entry, then the output register. Plain data bytes flow
// at one per cycle; a negotiation reply occupies the output for its 3 bytes (10
// for the terminal-type reply, 12 for DO NAWS), and the QUEUE_DEPTH-entry
// command queue keeps taking input meanwhile until it is full. Bytes that give
// no output (IAC, verbs, subnegotiation content) take no queue entry. Window
// size registers sit at byte addresses 0 and 4.

module telnet_client_stream_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// server byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// output byte channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             to_network,
	output logic             run_last,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]    cols_q;
	logic [15:0]    rows_q;
	logic           wr_en;
	logic           accept;
	logic           push;
	logic           pop;
	logic           full;
	logic           head_valid;
	tcsp_pkg::cmd_t push_cmd;
	tcsp_pkg::cmd_t head;

	// Configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tcsp_pkg::COLS_RESET;
			rows_q <= tcsp_pkg::ROWS_RESET;
		end else if (wr_en) begin
			if (paddr == tcsp_pkg::ADDR_COLS)
				cols_q <= pwdata[15:0];
			if (paddr == tcsp_pkg::ADDR_ROWS)
				rows_q <= pwdata[15:0];
		end
	end

	always_comb begin
		case (paddr)
			tcsp_pkg::ADDR_COLS: prdata = {16'h0000, cols_q};
			tcsp_pkg::ADDR_ROWS: prdata = {16'h0000, rows_q};
			default:             prdata = '0;
		endcase
	end

	// Input transfer
	assign in_stall = full;
	assign accept   = in_valid && !full;

	tcsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cmd     (push_cmd),
		.push    (push)
	);

	tcsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	tcsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cols       (cols_q),
		.rows       (rows_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.to_network (to_network),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

>>> tb/tcsp_reply_checker.sv
// tcsp_reply_checker: watches the server byte channel, the output byte channel
// and the configuration port of the telnet stream parser, predicts every output
// byte and compares. Depends on tcsp_pkg.
`timescale 1ns / 1ps

module tcsp_reply_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  out_byte,
	input  wire logic        to_network,
	input  wire logic        run_last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               mismatch_count,
	output int               outstanding
);

	// Receive parser states
	typedef enum logic [2:0] {
		PS_TEXT        = 3'd0,
		PS_CMD         = 3'd1,
		PS_SB_OPTION   = 3'd2,
		PS_VERB_OPTION = 3'd3,
		PS_SB_BODY     = 3'd4,
		PS_SB_IAC      = 3'd5
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       net;
		logic       last;
	} parser_out_t;

	parser_out_t  expected_out[$];
	parser_out_t  run_buf[$];

	parse_state_t state;
	logic [7:0]   verb_held;
	logic [7:0]   sb_option;
	logic [7:0]   sb_first;
	logic         sb_seen;
	logic [15:0]  cols;
	logic [15:0]  rows;

	task automatic put_byte(input logic [7:0] b, input logic net);
		parser_out_t r;
		r.data = b;
		r.net  = net;
		r.last = 1'b0;
		run_buf.push_back(r);
	endtask

	task automatic put_reply3(input logic [7:0] verb, input logic [7:0] opt);
		put_byte(tcsp_pkg::T_IAC, 1'b1);
		put_byte(verb, 1'b1);
		put_byte(opt, 1'b1);
	endtask

	// Answer to DO / DONT / WILL / WONT
	task automatic answer_verb(input logic [7:0] verb, input logic [7:0] opt);
		case (verb)
			tcsp_pkg::T_DO: begin
				if (opt == tcsp_pkg::OPT_WINSIZE) begin
					put_reply3(tcsp_pkg::T_WILL, tcsp_pkg::OPT_WINSIZE);
					put_byte(tcsp_pkg::T_IAC, 1'b1);
					put_byte(tcsp_pkg::T_SB, 1'b1);
					put_byte(tcsp_pkg::OPT_WINSIZE, 1'b1);
					// size bytes go out as they are, 0xFF not doubled
					put_byte(cols[15:8], 1'b1);
					put_byte(cols[7:0], 1'b1);
					put_byte(rows[15:8], 1'b1);
					put_byte(rows[7:0], 1'b1);
					put_byte(tcsp_pkg::T_IAC, 1'b1);
					put_byte(tcsp_pkg::T_SE, 1'b1);
				end else if (opt == tcsp_pkg::OPT_TTYPE) begin
					put_reply3(tcsp_pkg::T_WILL, tcsp_pkg::OPT_TTYPE);
				end else begin
					put_reply3(tcsp_pkg::T_WONT, opt);
				end
			end
			tcsp_pkg::T_DONT: put_reply3(tcsp_pkg::T_WONT, opt);
			tcsp_pkg::T_WILL: begin
				if (opt == tcsp_pkg::OPT_SGA || opt == tcsp_pkg::OPT_REMOTE_ECHO)
					put_reply3(tcsp_pkg::T_DO, opt);
				else
					put_reply3(tcsp_pkg::T_DONT, opt);
			end
			tcsp_pkg::T_WONT: put_reply3(tcsp_pkg::T_DONT, opt);
			default: ;
		endcase
	endtask

	task automatic note_sb_byte(input logic [7:0] b);
		if (!sb_seen) begin
			sb_first = b;
			sb_seen  = 1'b1;
		end
	endtask

	// One server byte through the receive state machine
	task automatic decode_rx_byte(input logic [7:0] b);
		parser_out_t r;
		run_buf.delete();
		case (state)
			PS_CMD: begin
				if (b == tcsp_pkg::T_IAC) begin
					put_byte(8'hFF, 1'b0);
					state = PS_TEXT;
				end else if (b == tcsp_pkg::T_DO || b == tcsp_pkg::T_DONT ||
						b == tcsp_pkg::T_WILL || b == tcsp_pkg::T_WONT) begin
					verb_held = b;
					state = PS_VERB_OPTION;
				end else if (b == tcsp_pkg::T_SB) begin
					sb_seen = 1'b0;
					state = PS_SB_OPTION;
				end else begin
					// unknown command is dropped
					state = PS_TEXT;
				end
			end
			PS_SB_OPTION: begin
				sb_option = b;
				sb_seen = 1'b0;
				state = PS_SB_BODY;
			end
			PS_VERB_OPTION: begin
				answer_verb(verb_held, b);
				state = PS_TEXT;
			end
			PS_SB_BODY: begin
				if (b == tcsp_pkg::T_IAC)
					state = PS_SB_IAC;
				else
					note_sb_byte(b);
			end
			PS_SB_IAC: begin
				if (b == tcsp_pkg::T_SE) begin
					if (sb_option == tcsp_pkg::OPT_TTYPE && sb_seen &&
							sb_first == tcsp_pkg::TTYPE_SEND) begin
						put_byte(tcsp_pkg::T_IAC, 1'b1);
						put_byte(tcsp_pkg::T_SB, 1'b1);
						put_byte(tcsp_pkg::OPT_TTYPE, 1'b1);
						put_byte(tcsp_pkg::TTYPE_IS, 1'b1);
						put_byte(tcsp_pkg::CH_A, 1'b1);
						put_byte(tcsp_pkg::CH_N, 1'b1);
						put_byte(tcsp_pkg::CH_S, 1'b1);
						put_byte(tcsp_pkg::CH_I, 1'b1);
						put_byte(tcsp_pkg::T_IAC, 1'b1);
						put_byte(tcsp_pkg::T_SE, 1'b1);
					end
					state = PS_TEXT;
				end else if (b == tcsp_pkg::T_IAC) begin
					// doubled IAC is a 0xFF body byte
					note_sb_byte(tcsp_pkg::T_IAC);
					state = PS_SB_BODY;
				end else begin
					// subnegotiation abandoned
					state = PS_TEXT;
				end
			end
			default: begin
				if (b == tcsp_pkg::T_IAC)
					state = PS_CMD;
				else
					put_byte(b, 1'b0);
			end
		endcase
		if (run_buf.size() > 0)
			run_buf[run_buf.size() - 1].last = 1'b1;
		foreach (run_buf[i]) begin
			r = run_buf[i];
			expected_out.push_back(r);
		end
	endtask

	// Compare one output transfer with the oldest expected byte
	task automatic check_out_byte();
		parser_out_t e;
		if (expected_out.size() == 0) begin
			$error("unexpected output byte %0h (to_network %0b run_last %0b)",
				out_byte, to_network, run_last);
			mismatch_count++;
			return;
		end
		e = expected_out.pop_front();
		if (out_byte !== e.data) begin
			$error("out_byte: expected %0h, got %0h", e.data, out_byte);
			mismatch_count++;
		end
		if (to_network !== e.net) begin
			$error("to_network: expected %0b, got %0b", e.net, to_network);
			mismatch_count++;
		end
		if (run_last !== e.last) begin
			$error("run_last: expected %0b, got %0b", e.last, run_last);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			expected_out.delete();
			state     = PS_TEXT;
			verb_held = 8'd0;
			sb_option = 8'd0;
			sb_first  = 8'd0;
			sb_seen   = 1'b0;
			cols      = tcsp_pkg::COLS_RESET;
			rows      = tcsp_pkg::ROWS_RESET;
		end else begin
			if (out_valid && !out_stall)
				check_out_byte();
			if (in_valid && !in_stall)
				decode_rx_byte(rx_byte);
			// register writes must come only while the parser is idle; not enforced here
			if (psel && penable && pwrite && pready) begin
				if (paddr == tcsp_pkg::ADDR_COLS)
					cols = pwdata[15:0];
				else if (paddr == tcsp_pkg::ADDR_ROWS)
					rows = pwdata[15:0];
			end
		end
		outstanding <= expected_out.size();
	end

endmodule

>>> tb/telnet_client_stream_parser_test.sv
// telnet_client_stream_parser_test: drives server bytes, window size writes and
// output back-pressure into the parser; tcsp_reply_checker predicts and compares.
// Depends on tcsp_pkg, telnet_client_stream_parser and tcsp_reply_checker.
`timescale 1ns / 1ps

module telnet_client_stream_parser_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        to_network;
	logic        run_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int outstanding;
	int cycle_count = 0;
	int stall_left = 0;
	int rx_sent = 0;
	bit send_eager = 1'b0;
	bit drain_eager = 1'b0;

	telnet_client_stream_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.to_network (to_network),
		.run_last   (run_last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	tcsp_reply_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.to_network     (to_network),
		.run_last       (run_last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Output back-pressure: after each transfer, unless drain_eager is set, hold stall for a random draw
	always @(posedge clk) begin : stall_gen
		int hold;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			hold = drain_eager ? 0 : $urandom_range(0, 8);
			out_stall <= (hold != 0);
			stall_left <= (hold == 0) ? 0 : hold - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One server byte transfer; returns at the edge that accepts it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_eager ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rx_sent++;
	endtask

	task automatic send_verb(input logic [7:0] verb, input logic [7:0] opt);
		send_byte(tcsp_pkg::T_IAC);
		send_byte(verb);
		send_byte(opt);
	endtask

	// IAC SB opt body IAC term; 0xFF body bytes are doubled
	task automatic send_subneg(input logic [7:0] opt, input int len,
			input logic [7:0] first, input logic [7:0] term);
		logic [7:0] b;
		send_byte(tcsp_pkg::T_IAC);
		send_byte(tcsp_pkg::T_SB);
		send_byte(opt);
		for (int i = 0; i < len; i++) begin
			b = (i == 0) ? first : 8'($urandom_range(0, 255));
			send_byte(b);
			if (b == tcsp_pkg::T_IAC)
				send_byte(tcsp_pkg::T_IAC);
		end
		send_byte(tcsp_pkg::T_IAC);
		send_byte(term);
	endtask

	// Let every expected byte arrive, then settle so that silent bytes are consumed too
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// One random protocol unit: mostly well-formed sequences, some noise
	task automatic send_random_unit();
		int pick;
		logic [7:0] verb;
		logic [7:0] opt;
		logic [7:0] first;
		logic [7:0] term;
		if ($urandom_range(0, 9) == 0)
			send_eager = !send_eager;
		if ($urandom_range(0, 9) == 0)
			drain_eager = !drain_eager;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_byte(8'($urandom_range(0, 254)));
		end else if (pick < 38) begin
			send_byte(tcsp_pkg::T_IAC);
			send_byte(tcsp_pkg::T_IAC);
		end else if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: verb = tcsp_pkg::T_DO;
				1: verb = tcsp_pkg::T_DONT;
				2: verb = tcsp_pkg::T_WILL;
				default: verb = tcsp_pkg::T_WONT;
			endcase
			case ($urandom_range(0, 5))
				0: opt = tcsp_pkg::OPT_WINSIZE;
				1: opt = tcsp_pkg::OPT_TTYPE;
				2: opt = tcsp_pkg::OPT_SGA;
				3: opt = tcsp_pkg::OPT_REMOTE_ECHO;
				default: opt = 8'($urandom_range(0, 255));
			endcase
			send_verb(verb, opt);
		end else if (pick < 80) begin
			case ($urandom_range(0, 4))
				0, 1, 2: opt = tcsp_pkg::OPT_TTYPE;
				3: opt = tcsp_pkg::OPT_WINSIZE;
				default: opt = 8'($urandom_range(0, 255));
			endcase
			first = ($urandom_range(0, 4) < 3) ? tcsp_pkg::TTYPE_SEND :
				8'($urandom_range(0, 255));
			// a few end in IAC plus something else, which abandons it
			term = ($urandom_range(0, 99) < 85) ? tcsp_pkg::T_SE :
				8'($urandom_range(0, 239));
			send_subneg(opt, $urandom_range(0, 3), first, term);
		end else if (pick < 90) begin
			// command that the parser drops
			send_byte(tcsp_pkg::T_IAC);
			send_byte(8'($urandom_range(0, 249)));
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int count);
		int start;
		start = rx_sent;
		while (rx_sent - start < count)
			send_random_unit();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset window size, one of each command kind
		send_byte(8'h00);
		send_byte(8'hFE);
		send_byte(tcsp_pkg::T_IAC);
		send_byte(tcsp_pkg::T_IAC);
		send_verb(tcsp_pkg::T_DO, tcsp_pkg::OPT_WINSIZE);
		send_verb(tcsp_pkg::T_DONT, tcsp_pkg::OPT_TTYPE);
		send_verb(tcsp_pkg::T_WILL, tcsp_pkg::OPT_REMOTE_ECHO);
		send_verb(tcsp_pkg::T_WONT, 8'd200);
		send_byte(tcsp_pkg::T_IAC);
		send_byte(8'd241);
		send_subneg(tcsp_pkg::OPT_TTYPE, 1, tcsp_pkg::TTYPE_SEND, tcsp_pkg::T_SE);
		run_random(25);
		wait_idle();

		// Smallest window size
		reg_write(tcsp_pkg::ADDR_COLS, 16'h0000);
		reg_write(tcsp_pkg::ADDR_ROWS, 16'h0000);
		send_verb(tcsp_pkg::T_DO, tcsp_pkg::OPT_WINSIZE);
		run_random(30);
		wait_idle();

		// Largest window size: every size byte is 0xFF
		reg_write(tcsp_pkg::ADDR_COLS, 16'hFFFF);
		reg_write(tcsp_pkg::ADDR_ROWS, 16'hFFFF);
		send_verb(tcsp_pkg::T_DO, tcsp_pkg::OPT_WINSIZE);
		run_random(30);
		wait_idle();

		// Random window size
		reg_write(tcsp_pkg::ADDR_COLS, 16'($urandom));
		reg_write(tcsp_pkg::ADDR_ROWS, 16'($urandom));
		send_verb(tcsp_pkg::T_DO, tcsp_pkg::OPT_WINSIZE);
		run_random(30);
		wait_idle();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/tcsp_pkg.sv
rtl/tcsp_front.sv
rtl/tcsp_queue.sv
rtl/tcsp_back.sv
rtl/telnet_client_stream_parser.sv
tb/tcsp_reply_checker.sv
tb/telnet_client_stream_parser_test.sv
